[src/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg: shared types and constants of the sorted key-value table
// Port field widths, parameter defaults, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  // Port field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // Parameter defaults
  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned DEF_KEY_BITS   = 32;
  localparam int unsigned DEF_VALUE_BITS = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

`default_nettype wire

[src/skvt_mem.sv]
// ----------------------------------------------------------------------------
// skvt_mem: entry storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/sorted_key_value_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table: bounded table of key-value pairs in ascending order
// Time from the accepting edge to the rising output valid grows with the
//   occupancy taken before the request: a lookup runs a linear scan, and an
//   insert or a remove runs a linear scan and then a one-entry-per-cycle shift
//   through the single RAM port pair.
// Requests: one at a time; the next request is taken once the result sits in
//   the output register, and the result waits for that register while the
//   output is stalled.
// Reset clears the entry count and the handshake state; the RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table #(
  parameter int unsigned CAPACITY   = skvt_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_BITS   = skvt_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = skvt_pkg::DEF_VALUE_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [skvt_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [skvt_pkg::KEY_W-1:0]     key_i,
  input  wire logic [skvt_pkg::VALUE_W-1:0]   value_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic                           found_o,
  output      logic [skvt_pkg::VALUE_W-1:0]   value_out_o,
  output      logic [skvt_pkg::COUNT_W-1:0]   entry_count_o,
  output      logic [skvt_pkg::STATUS_W-1:0]  status_o
);

  import skvt_pkg::*;

  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_DECIDE   = 7'b0000100,
    S_SHIFT_UP = 7'b0001000,
    S_PUT      = 7'b0010000,
    S_SHIFT_DN = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   occ_q, occ_d;
  logic            out_valid_q, out_valid_d;

  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [KW-1:0]   key_q, key_d;
  logic [VW-1:0]   val_q, val_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic            present_q, present_d;
  logic [VW-1:0]   rvalue_q, rvalue_d;
  status_e         status_q, status_d;

  logic               out_found_q, out_found_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  status_e            out_status_q, out_status_d;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [KW+VW-1:0]  mem_wdata;
  logic [IW-1:0]     mem_raddr;
  logic [KW+VW-1:0]  mem_rdata;
  logic [KW-1:0]     rd_key;
  logic [VW-1:0]     rd_val;

  assign rd_key = mem_rdata[KW+VW-1:VW];
  assign rd_val = mem_rdata[VW-1:0];

  skvt_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (KW + VW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    present_d    = present_q;
    rvalue_d     = rvalue_q;
    status_d     = status_q;
    out_found_d  = out_found_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = mem_rdata;
    mem_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = cmd_i;
          key_d     = KW'(key_i);
          val_d     = VW'(value_i);
          idx_d     = '0;
          pos_d     = '0;
          present_d = 1'b0;
          rvalue_d  = '0;
          state_d   = (occ_q == '0) ? S_DECIDE : S_SCAN;
        end
      end

      S_SCAN: begin
        // read ahead; rdata holds entry idx_q
        mem_raddr = idx_q + IW'(1);
        if (rd_key >= key_q) begin
          pos_d     = CW'(idx_q);
          present_d = (rd_key == key_q);
          if ((rd_key == key_q) && (cmd_q == CMD_LOOKUP)) begin
            rvalue_d = rd_val;
          end
          state_d = S_DECIDE;
        end else if (CW'(idx_q) + CW'(1) == occ_q) begin
          pos_d   = occ_q;
          state_d = S_DECIDE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      S_DECIDE: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (present_q) begin
              status_d = ST_DUP;
              state_d  = S_DONE;
            end else if (occ_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              status_d = ST_OK;
              if (pos_q == occ_q) begin
                state_d = S_PUT;
              end else begin
                // move entries up, starting at the last one
                mem_raddr = IW'(occ_q - CW'(1));
                idx_d     = IW'(occ_q - CW'(1));
                state_d   = S_SHIFT_UP;
              end
            end
          end
          CMD_LOOKUP: begin
            status_d = present_q ? ST_OK : ST_NOT_FOUND;
            state_d  = S_DONE;
          end
          CMD_REMOVE: begin
            if (!present_q) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              status_d = ST_OK;
              if (pos_q + CW'(1) == occ_q) begin
                occ_d   = occ_q - CW'(1);
                state_d = S_DONE;
              end else begin
                mem_raddr = IW'(pos_q + CW'(1));
                idx_d     = IW'(pos_q + CW'(1));
                state_d   = S_SHIFT_DN;
              end
            end
          end
          default: begin
            status_d = ST_OK;
            state_d  = S_DONE;
          end
        endcase
      end

      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q + IW'(1);
        mem_wdata = mem_rdata;
        if (CW'(idx_q) == pos_q) begin
          state_d = S_PUT;
        end else begin
          mem_raddr = idx_q - IW'(1);
          idx_d     = idx_q - IW'(1);
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(pos_q);
        mem_wdata = {key_q, val_q};
        occ_d     = occ_q + CW'(1);
        state_d   = S_DONE;
      end

      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q - IW'(1);
        mem_wdata = mem_rdata;
        if (CW'(idx_q) + CW'(1) == occ_q) begin
          occ_d   = occ_q - CW'(1);
          state_d = S_DONE;
        end else begin
          mem_raddr = idx_q + IW'(1);
          idx_d     = idx_q + IW'(1);
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_found_d  = present_q;
          out_value_d  = VALUE_W'(rvalue_q);
          out_count_d  = COUNT_W'(occ_q);
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    present_q    <= present_d;
    rvalue_q     <= rvalue_d;
    status_q     <= status_d;
    out_found_q  <= out_found_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign value_out_o   = out_value_q;
  assign entry_count_o = out_count_q;
  assign status_o      = out_status_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_dup_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_DUP)) |-> found_o)
    else $error("duplicate status without found");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |->
      (!found_o && (entry_count_o == COUNT_W'(CAPACITY))))
    else $error("full status with table not full");

  a_ready_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("request finished without a result");

endmodule

`default_nettype wire
